// ===== hw/rtl/stm_pkg.sv =====
// ----------------------------------------------------------------------------
// stm_pkg
// shared sizes, opcodes and the result record of the range minimum tree
// ----------------------------------------------------------------------------
package stm_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int NODE_COUNT   = 4 * MAX_ELEMENTS;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int LEN_W        = 11;
  localparam int VAL_W        = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
    logic                    empty;
  } result_t;

endpackage

// ===== hw/rtl/stm_ram.sv =====
// ----------------------------------------------------------------------------
// stm_ram
// simple dual port synchronous memory, one write and one registered read
// ----------------------------------------------------------------------------
module stm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/stm_walker.sv =====
// ----------------------------------------------------------------------------
// stm_walker
// sequencer that walks the tree in memory for writes, queries and rebuilds
// ----------------------------------------------------------------------------
module stm_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [stm_pkg::LEN_W-1:0]     live_len,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [stm_pkg::IDX_W-1:0]     element_index,
  input  logic signed [stm_pkg::VAL_W-1:0] new_value,
  input  logic [stm_pkg::IDX_W-1:0]     range_low,
  input  logic [stm_pkg::IDX_W-1:0]     range_high,
  output stm_pkg::result_t              res,
  input  logic                          res_ack
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_W_DESC, ST_W_VAL, ST_W_SIB, ST_W_SVAL, ST_W_CMP,
    ST_Q_SPLIT, ST_Q_LEFT, ST_Q_RIGHT, ST_T_NODE, ST_T_VAL, ST_T_CMP, ST_Q_DONE
  } state_t;

  state_t state;
  state_t ret_state;

  logic [stm_pkg::NODE_W-1:0] node, take_node, rnode;
  logic [stm_pkg::IDX_W-1:0]  l, r, rl, rr, lo, hi;
  logic [stm_pkg::IDX_W-1:0]  cur_idx, cur_win, tk_win, best_win;
  logic signed [stm_pkg::VAL_W-1:0] cur_val, best_val;
  logic                       have_best, take_left, res_empty;
  logic                       pass_active, pass_zero;
  logic [stm_pkg::LEN_W-1:0]  pass_idx;

  // memory ports
  logic                       v_we, n_we;
  logic [stm_pkg::IDX_W-1:0]  v_waddr, v_raddr;
  logic [stm_pkg::VAL_W-1:0]  v_wdata, v_rdata;
  logic [stm_pkg::NODE_W-1:0] n_waddr, n_raddr;
  logic [stm_pkg::IDX_W-1:0]  n_wdata, n_rdata;

  logic                       accept;
  logic [stm_pkg::IDX_W-1:0]  mid, live_m1, hi_c;
  logic [stm_pkg::IDX_W:0]    mid_sum;
  logic [stm_pkg::NODE_W-1:0] left_ch, right_ch, parent, sib;
  logic [stm_pkg::LEN_W-1:0]  pass_limit;
  logic                       q_empty, sib_wins, cand_wins;
  logic signed [stm_pkg::VAL_W-1:0] rd_val;

  stm_ram #(.WIDTH(stm_pkg::VAL_W), .DEPTH(stm_pkg::MAX_ELEMENTS)) u_values (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  stm_ram #(.WIDTH(stm_pkg::IDX_W), .DEPTH(stm_pkg::NODE_COUNT)) u_nodes (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  assign in_stall = !(state == ST_IDLE && !pass_active);
  assign accept   = in_valid && !in_stall;
  assign live_m1  = stm_pkg::IDX_W'(live_len - stm_pkg::LEN_W'(1));
  assign mid_sum  = {1'b0, l} + {1'b0, r};
  assign mid      = mid_sum[stm_pkg::IDX_W:1];
  assign left_ch  = {node[stm_pkg::NODE_W-2:0], 1'b1};
  assign right_ch = stm_pkg::NODE_W'({node, 1'b0} + (stm_pkg::NODE_W+1)'(2));
  assign parent   = stm_pkg::NODE_W'((node - stm_pkg::NODE_W'(1)) >> 1);
  assign sib      = node[0] ? node + stm_pkg::NODE_W'(1) : node - stm_pkg::NODE_W'(1);
  assign pass_limit = pass_zero ? stm_pkg::LEN_W'(stm_pkg::MAX_ELEMENTS) : live_len;
  assign hi_c     = ({1'b0, range_high} >= live_len) ? live_m1 : range_high;
  assign q_empty  = (range_low > hi_c) || ({1'b0, range_low} >= live_len);
  assign rd_val   = $signed(v_rdata);
  // ours on the left keeps ties, sibling on the left takes them
  assign sib_wins = node[0] ? (rd_val < cur_val) : (rd_val <= cur_val);
  // left path visits leftward, right path rightward
  assign cand_wins = !have_best || (take_left ? (rd_val <= best_val) : (rd_val < best_val));

  always_comb begin
    v_we    = 1'b0;
    v_waddr = element_index;
    v_wdata = new_value;
    if (accept && opcode == stm_pkg::OP_WRITE) begin
      v_we = 1'b1;
    end else if (state == ST_IDLE && pass_active && pass_idx != pass_limit && pass_zero) begin
      v_we    = 1'b1;
      v_waddr = pass_idx[stm_pkg::IDX_W-1:0];
      v_wdata = '0;
    end
    v_raddr = cur_idx;
    if (state == ST_W_SVAL || state == ST_T_VAL) begin
      v_raddr = n_rdata;
    end

    n_we    = 1'b0;
    n_waddr = node;
    n_wdata = cur_idx;
    n_raddr = take_node;
    unique case (state)
      ST_W_DESC: begin
        n_we = (l == r);
      end
      ST_W_SIB: begin
        n_raddr = sib;
      end
      ST_W_CMP: begin
        n_we    = 1'b1;
        n_waddr = parent;
        n_wdata = sib_wins ? tk_win : cur_win;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ret_state   <= ST_IDLE;
      pass_active <= 1'b1;
      pass_zero   <= 1'b1;
      pass_idx    <= '0;
      have_best   <= 1'b0;
      res_empty   <= 1'b0;
    end else if (restart) begin
      state       <= ST_IDLE;
      pass_active <= 1'b1;
      pass_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pass_active) begin
            if (pass_idx == pass_limit) begin
              pass_active <= 1'b0;
              pass_zero   <= 1'b0;
            end else begin
              pass_idx <= pass_idx + stm_pkg::LEN_W'(1);
              cur_idx  <= pass_idx[stm_pkg::IDX_W-1:0];
              node     <= '0;
              l        <= '0;
              r        <= live_m1;
              if (pass_idx < live_len) begin
                state <= ST_W_DESC;
              end
            end
          end else if (accept) begin
            node <= '0;
            l    <= '0;
            r    <= live_m1;
            if (opcode == stm_pkg::OP_WRITE) begin
              cur_idx <= element_index;
              if ({1'b0, element_index} < live_len) begin
                state <= ST_W_DESC;
              end
            end else begin
              lo        <= range_low;
              hi        <= hi_c;
              have_best <= 1'b0;
              res_empty <= q_empty;
              state     <= q_empty ? ST_Q_DONE : ST_Q_SPLIT;
            end
          end
        end
        ST_W_DESC: begin
          if (l == r) begin
            state <= ST_W_VAL;
          end else if (cur_idx <= mid) begin
            node <= left_ch;
            r    <= mid;
          end else begin
            node <= right_ch;
            l    <= mid + stm_pkg::IDX_W'(1);
          end
        end
        ST_W_VAL: begin
          cur_val <= rd_val;
          cur_win <= cur_idx;
          state   <= (node == '0) ? ST_IDLE : ST_W_SIB;
        end
        ST_W_SIB: begin
          state <= ST_W_SVAL;
        end
        ST_W_SVAL: begin
          tk_win <= n_rdata;
          state  <= ST_W_CMP;
        end
        ST_W_CMP: begin
          if (sib_wins) begin
            cur_win <= tk_win;
            cur_val <= rd_val;
          end
          node  <= parent;
          state <= (parent == '0) ? ST_IDLE : ST_W_SIB;
        end
        ST_Q_SPLIT: begin
          if (lo <= l && r <= hi) begin
            take_node <= node;
            ret_state <= ST_Q_DONE;
            state     <= ST_T_NODE;
          end else if (hi <= mid) begin
            node <= left_ch;
            r    <= mid;
          end else if (lo > mid) begin
            node <= right_ch;
            l    <= mid + stm_pkg::IDX_W'(1);
          end else begin
            rnode <= right_ch;
            rl    <= mid + stm_pkg::IDX_W'(1);
            rr    <= r;
            node  <= left_ch;
            r     <= mid;
            state <= ST_Q_LEFT;
          end
        end
        ST_Q_LEFT: begin
          take_left <= 1'b1;
          if (lo <= l) begin
            take_node <= node;
            ret_state <= ST_Q_RIGHT;
            node      <= rnode;
            l         <= rl;
            r         <= rr;
            state     <= ST_T_NODE;
          end else if (lo <= mid) begin
            take_node <= right_ch;
            ret_state <= ST_Q_LEFT;
            node      <= left_ch;
            r         <= mid;
            state     <= ST_T_NODE;
          end else begin
            node <= right_ch;
            l    <= mid + stm_pkg::IDX_W'(1);
          end
        end
        ST_Q_RIGHT: begin
          take_left <= 1'b0;
          if (r <= hi) begin
            take_node <= node;
            ret_state <= ST_Q_DONE;
            state     <= ST_T_NODE;
          end else if (hi > mid) begin
            take_node <= left_ch;
            ret_state <= ST_Q_RIGHT;
            node      <= right_ch;
            l         <= mid + stm_pkg::IDX_W'(1);
            state     <= ST_T_NODE;
          end else begin
            node <= left_ch;
            r    <= mid;
          end
        end
        ST_T_NODE: begin
          state <= ST_T_VAL;
        end
        ST_T_VAL: begin
          tk_win <= n_rdata;
          state  <= ST_T_CMP;
        end
        ST_T_CMP: begin
          if (cand_wins) begin
            best_win <= tk_win;
            best_val <= rd_val;
          end
          have_best <= 1'b1;
          state     <= ret_state;
        end
        ST_Q_DONE: begin
          if (res_ack) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.valid = (state == ST_Q_DONE);
    res.empty = res_empty;
    res.value = res_empty ? '0 : best_val;
    res.index = res_empty ? '0 : best_win;
  end

  a_pass_stalls: assert property (@(posedge clk) disable iff (rst)
    pass_active |-> in_stall) else $error("item taken during rebuild");

  a_restart_pass: assert property (@(posedge clk) disable iff (rst)
    restart |=> pass_active) else $error("rebuild not started");

  a_done_has_best: assert property (@(posedge clk) disable iff (rst)
    (state == ST_Q_DONE && !res_empty) |-> have_best)
    else $error("query finished with no candidate");

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == stm_pkg::OP_QUERY && !q_empty) |=> (state == ST_Q_SPLIT))
    else $error("query did not start its descent");

endmodule

// ===== hw/rtl/segment_tree_range_min.sv =====
// ----------------------------------------------------------------------------
// segment_tree_range_min
// range minimum over signed elements, segment tree of winner indexes in ram
// ----------------------------------------------------------------------------
// write: descent, then a sibling compare and parent write per level going up
// query: descent plus a winner read and compare per covering node
// one item at a time; each compared node costs a node ram and a value ram read
// after reset the block clears every element and builds the tree, and
// a used_length write rebuilds over the used elements
// ----------------------------------------------------------------------------
module segment_tree_range_min (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             used_length_we,
  input  logic [stm_pkg::LEN_W-1:0]        used_length,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [stm_pkg::IDX_W-1:0]        element_index,
  input  logic signed [stm_pkg::VAL_W-1:0] new_value,
  input  logic [stm_pkg::IDX_W-1:0]        range_low,
  input  logic [stm_pkg::IDX_W-1:0]        range_high,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [stm_pkg::VAL_W-1:0] min_value,
  output logic [stm_pkg::IDX_W-1:0]        min_index,
  output logic                             empty_range
);

  logic [stm_pkg::LEN_W-1:0] len_reg, live_len;
  stm_pkg::result_t          res;
  logic                      res_ack;

  // zero acts as one, anything past the array acts as its size
  assign live_len = (len_reg == '0) ? stm_pkg::LEN_W'(1) :
                    (len_reg > stm_pkg::LEN_W'(stm_pkg::MAX_ELEMENTS)) ?
                    stm_pkg::LEN_W'(stm_pkg::MAX_ELEMENTS) : len_reg;

  assign res_ack = res.valid && (!out_valid || !out_stall);

  stm_walker u_walker (
    .clk(clk), .rst(rst), .restart(used_length_we), .live_len(live_len),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
    .element_index(element_index), .new_value(new_value),
    .range_low(range_low), .range_high(range_high),
    .res(res), .res_ack(res_ack)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg   <= stm_pkg::LEN_W'(stm_pkg::MAX_ELEMENTS);
      out_valid <= 1'b0;
    end else begin
      if (used_length_we) begin
        len_reg <= used_length;
      end
      if (res_ack) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (res_ack) begin
      min_value   <= res.value;
      min_index   <= res.index;
      empty_range <= res.empty;
    end
  end

endmodule
